@@ hdl/mhp_pkg.sv @@
package mhp_pkg;

   localparam int unsigned ADDR_W = 48;
   localparam int unsigned CONF_W = 8;
   localparam logic [63:0] HASH_SEED = 64'h165667b1d3a2646c;
   localparam int unsigned RESULT_CAP = 4;

   // configuration register indexes
   localparam logic [2:0] REG_BLOCK_SIZE_LOG2 = 3'd0;
   localparam logic [2:0] REG_ISSUE_DEGREE = 3'd1;
   localparam logic [2:0] REG_CANDIDATE_LIMIT = 3'd2;
   localparam logic [2:0] REG_CONF_THRESHOLD = 3'd3;
   localparam logic [2:0] REG_CONF_CEILING = 3'd4;
   localparam logic [2:0] REG_CONF_START = 3'd5;

   typedef struct packed {
      logic [3:0] block_size_log2;
      logic [2:0] issue_degree;
      logic [2:0] candidate_limit;
      logic [7:0] confidence_threshold;
      logic [7:0] confidence_ceiling;
      logic [7:0] confidence_start;
   } cfg_type;

   // arithmetic right shift of a 64-bit word
   function automatic logic [63:0] asr(input logic [63:0] x, input int unsigned n);
      asr = 64'($signed(x) >>> n);
   endfunction

   // one hash mixing round (six adds deep)
   function automatic logic [63:0] mix(input logic [63:0] k_in);
      logic [63:0] k;
      k = (~k_in) + (k_in << 21);
      k = k ^ asr(k, 24);
      k = (k + (k << 3)) + (k << 8);
      k = k ^ asr(k, 14);
      k = (k + (k << 2)) + (k << 4);
      k = k ^ asr(k, 28);
      k = k + (k << 31);
      mix = k;
   endfunction

endpackage

@@ hdl/mhp_hash.sv @@
// Iterative history hash: one mix stage per cycle.
// Each slot takes three mix steps: mix(h), mix(b), mix(mix(b)).
module mhp_hash #(
   parameter int unsigned HISTORY_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [HISTORY_DEPTH-1:0][mhp_pkg::ADDR_W-1:0] history,
   output logic done,
   output logic [63:0] hash
);

   localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [1:0] phase_ff, phase_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] mh_ff, mh_in;
   logic [63:0] mb_ff, mb_in;
   logic [63:0] mix_arg, mix_out;

   always_comb begin
      unique case (phase_ff)
         2'd0: mix_arg = h_ff;
         2'd1: mix_arg = {16'd0, history[slot_ff]};
         default: mix_arg = mb_ff;
      endcase
      mix_out = mhp_pkg::mix(mix_arg);
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      phase_in = phase_ff;
      slot_in = slot_ff;
      h_in = h_ff;
      mh_in = mh_ff;
      mb_in = mb_ff;
      if (start) begin
         busy_in = 1'b1;
         phase_in = 2'd0;
         slot_in = '0;
         h_in = mhp_pkg::HASH_SEED;
      end else if (busy_ff) begin
         priority if (phase_ff == 2'd0) begin
            mh_in = mix_out;
            phase_in = 2'd1;
         end else if (phase_ff == 2'd1) begin
            mb_in = mix_out;
            phase_in = 2'd2;
         end else begin
            h_in = mh_ff ^ mix_out;
            phase_in = 2'd0;
            if (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         phase_ff <= 2'd0;
         slot_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         phase_ff <= phase_in;
         slot_ff <= slot_in;
      end
      h_ff <= h_in;
      mh_ff <= mh_in;
      mb_ff <= mb_in;
   end

   assign done = done_ff;
   assign hash = h_ff;

   // done is a single pulse
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("hash done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("hash done without run");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("hash phase invalid");

endmodule

@@ hdl/markov_history_prefetcher.sv @@
// Markov history prefetcher. Each accepted access word is reduced to its block
// address; a repeat of the previous block is dropped. Otherwise two keys are hashed
// over the block history (before and after the new block is pushed), the older key's
// table entry is trained with the new block, and the newer key's entry is sorted
// by confidence, written back, and its confident targets go out as prefetch words,
// the last flagged by rsp_last_of_run. The key is the low bits of the hash, so
// TABLE_ENTRIES must be a power of two. Keys are computed by one shared mix unit,
// one mix step per cycle. A new access is taken only in idle: a non-dropped access
// holds off the next until its hashes, training, sort and emission are done, and
// output stalls hold the emission; one whose newer entry is absent skips the
// emission; a dropped access goes back to idle from the check. The table is one
// synchronous memory holding a whole entry per row, read then written back.
// After reset a clearing pass writes every table row to zero before the first
// access is taken.
module markov_history_prefetcher #(
   parameter int unsigned TABLE_ENTRIES = 1024,
   parameter int unsigned MAX_CANDIDATES = 4,
   parameter int unsigned HISTORY_DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [47:0] req_access_address,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [47:0] rsp_prefetch_address,
   output logic rsp_last_of_run,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int unsigned AW = mhp_pkg::ADDR_W;
   localparam int unsigned CW = mhp_pkg::CONF_W;
   localparam int unsigned KEY_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
   localparam int unsigned POS_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int unsigned CLR_W = $clog2(TABLE_ENTRIES + 1);
   localparam int unsigned OUT_W = $clog2(MAX_CANDIDATES + 1);

   typedef struct packed {
      logic present;
      logic [CNT_W-1:0] count;
      logic [MAX_CANDIDATES-1:0][AW-1:0] target;
      logic [MAX_CANDIDATES-1:0][CW-1:0] conf;
   } entry_type;

   typedef enum logic [9:0] {
      ST_CLEAR   = 10'b0000000001,
      ST_IDLE    = 10'b0000000010,
      ST_CHECK   = 10'b0000000100,
      ST_HASH0   = 10'b0000001000,
      ST_HASH1   = 10'b0000010000,
      ST_RD0     = 10'b0000100000,
      ST_TRAIN   = 10'b0001000000,
      ST_RD1     = 10'b0010000000,
      ST_SORT    = 10'b0100000000,
      ST_EMIT    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   mhp_pkg::cfg_type cfg_ff, cfg_in;

   logic [AW-1:0] prev_ff, prev_in;
   logic [AW-1:0] blk_ff, blk_in;
   logic [HISTORY_DEPTH-1:0][AW-1:0] hist_ff, hist_in;
   logic [KEY_W-1:0] key0_ff, key0_in, key1_ff, key1_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic sort_ff, sort_in;
   entry_type ent_ff, ent_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [OUT_W-1:0] idx_ff, idx_in;
   logic [2:0] sent_ff, sent_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0] rsp_addr_ff, rsp_addr_in;
   logic rsp_last_ff, rsp_last_in;

   // table memory
   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;
   logic [KEY_W-1:0] rd_addr;
   logic wr_en;
   logic [KEY_W-1:0] wr_addr;
   entry_type wr_data;

   logic hash_start, hash_done;
   logic [63:0] hash_val;

   mhp_hash #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hash (
      .clock(clock), .reset(reset), .start(hash_start), .history(hist_ff),
      .done(hash_done), .hash(hash_val)
   );

   logic [KEY_W-1:0] hash_key;
   assign hash_key = hash_val[KEY_W-1:0] & KEY_W'(TABLE_ENTRIES - 1);

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   // training of a present entry
   function automatic entry_type train(input entry_type e, input logic [AW-1:0] b,
                                       input mhp_pkg::cfg_type c);
      entry_type r;
      logic hit;
      logic [CNT_W-1:0] n, lim;
      logic [POS_W-1:0] mi;
      r = e;
      hit = 1'b0;
      n = (e.count > CNT_W'(MAX_CANDIDATES)) ? CNT_W'(MAX_CANDIDATES) : e.count;
      lim = (32'(c.candidate_limit) > MAX_CANDIDATES) ?
            CNT_W'(MAX_CANDIDATES) : CNT_W'(c.candidate_limit);
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
         if (CNT_W'(i) < n) begin
            if (e.target[i] != b) begin
               if (e.conf[i] != '0) r.conf[i] = e.conf[i] - 1'b1;
            end else if (!hit) begin
               hit = 1'b1;
               if (e.conf[i] < c.confidence_ceiling) r.conf[i] = e.conf[i] + 1'b1;
            end
         end
      end
      if (!hit) begin
         if (n < lim) begin
            r.target[POS_W'(n)] = b;
            r.conf[POS_W'(n)] = c.confidence_start;
            r.count = n + 1'b1;
         end else if (n != '0) begin
            mi = '0;
            for (int i = 1; i < MAX_CANDIDATES; i++)
               if (CNT_W'(i) < n && r.conf[i] < r.conf[mi]) mi = POS_W'(i);
            if (r.conf[mi] < c.confidence_threshold) begin
               r.conf[mi] = c.confidence_start;
               r.target[mi] = b;
            end
         end
      end
      train = r;
   endfunction

   logic [AW-1:0] req_blk;
   logic [AW-1:0] blk_mask;
   assign blk_mask = ~((AW'(1) << cfg_ff.block_size_log2) - AW'(1));
   assign req_blk = req_access_address & blk_mask;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mhp_pkg::REG_BLOCK_SIZE_LOG2: cfg_in.block_size_log2 = csr_data[3:0];
            mhp_pkg::REG_ISSUE_DEGREE: cfg_in.issue_degree = csr_data[2:0];
            mhp_pkg::REG_CANDIDATE_LIMIT: cfg_in.candidate_limit = csr_data[2:0];
            mhp_pkg::REG_CONF_THRESHOLD: cfg_in.confidence_threshold = csr_data;
            mhp_pkg::REG_CONF_CEILING: cfg_in.confidence_ceiling = csr_data;
            mhp_pkg::REG_CONF_START: cfg_in.confidence_start = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      entry_type nt;
      state_in = state_ff;
      prev_in = prev_ff;
      blk_in = blk_ff;
      hist_in = hist_ff;
      key0_in = key0_ff;
      key1_in = key1_ff;
      clr_in = clr_ff;
      sort_in = sort_ff;
      ent_in = ent_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      sent_in = sent_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_last_in = rsp_last_ff;
      hash_start = 1'b0;
      rd_addr = key0_ff;
      wr_en = 1'b0;
      wr_addr = key0_ff;
      wr_data = ent_ff;
      nt = ent_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = KEY_W'(clr_ff);
            wr_data = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(TABLE_ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               blk_in = req_blk;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (blk_ff == prev_ff) begin
               state_in = ST_IDLE;
            end else begin
               prev_in = blk_ff;
               hash_start = 1'b1;
               state_in = ST_HASH0;
            end
         end
         ST_HASH0: begin
            if (hash_done) begin
               key0_in = hash_key;
               for (int k = HISTORY_DEPTH - 1; k > 0; k--) hist_in[k] = hist_ff[k-1];
               hist_in[0] = blk_ff;
               state_in = ST_HASH1;
            end
         end
         ST_HASH1: begin
            if (hist_ff[0] == blk_ff && !hash_done && !sort_ff) begin
               hash_start = 1'b1;
               sort_in = 1'b1;
            end else if (hash_done) begin
               key1_in = hash_key;
               sort_in = 1'b0;
               rd_addr = key0_ff;
               state_in = ST_RD0;
            end
         end
         ST_RD0: begin
            state_in = ST_TRAIN;
         end
         ST_TRAIN: begin
            if (!rd_data_ff.present) begin
               nt = '0;
               nt.present = 1'b1;
               nt.count = CNT_W'(1);
               nt.target[0] = blk_ff;
               nt.conf[0] = cfg_ff.confidence_threshold;
            end else begin
               nt = train(rd_data_ff, blk_ff, cfg_ff);
            end
            wr_en = 1'b1;
            wr_addr = key0_ff;
            wr_data = nt;
            rd_addr = key1_ff;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            // read issued last cycle; forward a same-key write
            ent_in = (key1_ff == key0_ff) ? ent_ff : rd_data_ff;
            state_in = ST_SORT;
            pos_in = POS_W'(1);
         end
         ST_SORT: begin
            if (!ent_ff.present) begin
               state_in = ST_IDLE;
            end else begin
               // one insertion pass per cycle (bubble of element pos into sorted prefix)
               for (int j = MAX_CANDIDATES - 1; j > 0; j--) begin
                  if (POS_W'(j) <= pos_ff && CNT_W'(j) < ent_in.count &&
                      ent_in.conf[j-1] < ent_in.conf[j]) begin
                     nt = ent_in;
                     ent_in.conf[j-1] = nt.conf[j];
                     ent_in.conf[j] = nt.conf[j-1];
                     ent_in.target[j-1] = nt.target[j];
                     ent_in.target[j] = nt.target[j-1];
                  end
               end
               if (32'(pos_ff) + 1 >= MAX_CANDIDATES) begin
                  // sorted order is kept in the table
                  wr_en = 1'b1;
                  wr_addr = key1_ff;
                  wr_data = ent_in;
                  state_in = ST_EMIT;
                  idx_in = '0;
                  sent_in = '0;
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               if (32'(idx_ff) >= 32'(cfg_ff.issue_degree)
                   || 32'(sent_ff) >= 32'(mhp_pkg::RESULT_CAP)
                   || idx_ff >= OUT_W'(MAX_CANDIDATES) || CNT_W'(idx_ff) >= ent_ff.count
                   || ent_ff.conf[POS_W'(idx_ff)] < cfg_ff.confidence_threshold) begin
                  if (sent_ff != '0 && rsp_valid_ff) rsp_last_in = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  if (ent_ff.target[POS_W'(idx_ff)] != blk_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_addr_in = ent_ff.target[POS_W'(idx_ff)];
                     rsp_last_in = 1'b0;
                     sent_in = sent_ff + 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Last flag: set on a word as it is loaded when no later word of the run follows.
   // a later candidate can stop the run early; find the first stop point
   logic more_follow;
   always_comb begin
      logic stop;
      more_follow = 1'b0;
      stop = (32'(sent_ff) + 32'd1 >= 32'(mhp_pkg::RESULT_CAP));
      for (int i = 0; i < MAX_CANDIDATES; i++) begin
         if (OUT_W'(i) > idx_ff && !stop) begin
            if (32'(i) >= 32'(cfg_ff.issue_degree) || CNT_W'(i) >= ent_ff.count ||
                ent_ff.conf[i] < cfg_ff.confidence_threshold) begin
               stop = 1'b1;
            end else if (ent_ff.target[i] != blk_ff) begin
               more_follow = 1'b1;
               stop = 1'b1;
            end
         end
      end
   end

   logic emit_now;
   assign emit_now = (state_ff == ST_EMIT) && rsp_free && (state_in == ST_EMIT) &&
                     (idx_in != idx_ff) && rsp_valid_in && !(rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         cfg_ff <= '{block_size_log2: 4'd6, issue_degree: 3'd2, candidate_limit: 3'd4,
                     confidence_threshold: 8'd1, confidence_ceiling: 8'd3,
                     confidence_start: 8'd1};
         prev_ff <= '0;
         hist_ff <= '0;
         sort_ff <= 1'b0;
         sent_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         cfg_ff <= cfg_in;
         prev_ff <= prev_in;
         hist_ff <= hist_in;
         sort_ff <= sort_in;
         sent_ff <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      blk_ff <= blk_in;
      key0_ff <= key0_in;
      key1_ff <= key1_in;
      ent_ff <= (state_ff == ST_TRAIN && key1_ff == key0_ff) ? wr_data : ent_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= emit_now ? !more_follow : rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prefetch_address = rsp_addr_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // no input taken outside idle
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> state_ff == ST_IDLE) else $error("req taken while busy");
   a_one_hot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_write_in_train: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_CLEAR) |-> (state_ff == ST_TRAIN || state_ff == ST_SORT))
      else $error("stray write");
   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      sent_ff <= 3'(mhp_pkg::RESULT_CAP)) else $error("too many prefetches");

endmodule

@@ dv/tb_markov_history_prefetcher.sv @@
module tb_markov_history_prefetcher;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ENTRIES = 1024;
   localparam int unsigned SLOTS = 4;
   localparam int unsigned DEPTH = 4;
   localparam int unsigned SETTLE = 80;
   localparam int unsigned PHASES = 8;
   localparam int unsigned PHASE_ITEMS = 25;

   typedef struct packed {
      logic [47:0] addr;
      logic        last;
   } prefetch_word_type;

   typedef struct {
      bit          is_csr;
      logic [2:0]  idx;
      logic [47:0] value;
      int          want_n;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [47:0] req_access_address = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [47:0] rsp_prefetch_address;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   // shadow of the block: configuration and learned table
   mhp_pkg::cfg_type shadow_cfg;
   logic [47:0] last_block;
   logic [47:0] hist [DEPTH];
   bit          valid_row [ENTRIES];
   logic [2:0]  row_count [ENTRIES];
   logic [47:0] succ_block [ENTRIES][SLOTS];
   logic [7:0]  succ_conf [ENTRIES][SLOTS];

   prefetch_word_type prefetch_q[$];
   int  errors = 0;
   bit  quiet = 0;

   markov_history_prefetcher dut (.*);

   always #5 clock = ~clock;

   initial begin
      #3000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [63:0] hash_round(input logic [63:0] v);
      logic [63:0] k;
      k = (~v) + (v << 21);
      k = k ^ 64'($signed(k) >>> 24);
      k = (k + (k << 3)) + (k << 8);
      k = k ^ 64'($signed(k) >>> 14);
      k = (k + (k << 2)) + (k << 4);
      k = k ^ 64'($signed(k) >>> 28);
      k = k + (k << 31);
      return k;
   endfunction

   function automatic int unsigned history_row();
      logic [63:0] h;
      h = mhp_pkg::HASH_SEED;
      for (int i = 0; i < DEPTH; i++)
         h = hash_round(h) ^ hash_round(hash_round({16'd0, hist[i]}));
      return int'(h % ENTRIES);
   endfunction

   function automatic void learn(input int unsigned r, input logic [47:0] blk);
      int n, lim, mi;
      if (!valid_row[r]) begin
         valid_row[r] = 1;
         row_count[r] = 3'd1;
         succ_block[r][0] = blk;
         succ_conf[r][0] = shadow_cfg.confidence_threshold;
         return;
      end
      n = (row_count[r] > SLOTS) ? SLOTS : row_count[r];
      for (int i = 0; i < n; i++)
         if (succ_block[r][i] != blk && succ_conf[r][i] > 0)
            succ_conf[r][i]--;
      for (int i = 0; i < n; i++)
         if (succ_block[r][i] == blk) begin
            if (succ_conf[r][i] < shadow_cfg.confidence_ceiling)
               succ_conf[r][i]++;
            return;
         end
      lim = (shadow_cfg.candidate_limit > SLOTS) ? SLOTS : shadow_cfg.candidate_limit;
      if (n < lim) begin
         succ_block[r][n] = blk;
         succ_conf[r][n] = shadow_cfg.confidence_start;
         row_count[r] = 3'(n + 1);
         return;
      end
      if (n == 0)
         return;
      // weakest successor, first on ties
      mi = 0;
      for (int i = 1; i < n; i++)
         if (succ_conf[r][i] < succ_conf[r][mi])
            mi = i;
      if (succ_conf[r][mi] < shadow_cfg.confidence_threshold) begin
         succ_conf[r][mi] = shadow_cfg.confidence_start;
         succ_block[r][mi] = blk;
      end
   endfunction

   // returns number of prefetch words queued, -1 when the access is dropped
   function automatic int predict_access(input logic [47:0] addr);
      logic [47:0] blk, tb;
      logic [7:0]  tc;
      int unsigned pk, ck;
      int n, j, cnt;
      logic [47:0] outs [4];
      blk = addr & ~((48'd1 << shadow_cfg.block_size_log2) - 48'd1);
      if (blk == last_block)
         return -1;
      last_block = blk;
      pk = history_row();
      for (int k = DEPTH - 1; k > 0; k--)
         hist[k] = hist[k - 1];
      hist[0] = blk;
      ck = history_row();
      learn(pk, blk);
      if (!valid_row[ck])
         return 0;
      n = (row_count[ck] > SLOTS) ? SLOTS : row_count[ck];
      // stable sort, strongest first, written back
      for (int i = 1; i < n; i++) begin
         tb = succ_block[ck][i];
         tc = succ_conf[ck][i];
         j = i;
         while (j > 0 && succ_conf[ck][j - 1] < tc) begin
            succ_block[ck][j] = succ_block[ck][j - 1];
            succ_conf[ck][j] = succ_conf[ck][j - 1];
            j--;
         end
         succ_block[ck][j] = tb;
         succ_conf[ck][j] = tc;
      end
      cnt = 0;
      for (int i = 0; i < shadow_cfg.issue_degree && cnt < mhp_pkg::RESULT_CAP; i++) begin
         if (i >= n || succ_conf[ck][i] < shadow_cfg.confidence_threshold)
            break;
         if (succ_block[ck][i] != blk) begin
            outs[cnt] = succ_block[ck][i];
            cnt++;
         end
      end
      for (int i = 0; i < cnt; i++)
         prefetch_q.push_back('{addr: outs[i], last: (i == cnt - 1)});
      return cnt;
   endfunction

   function automatic void flag(input string what);
      errors++;
      if (errors <= 10)
         $display("ERROR: %s", what);
   endfunction

   // access word; valid stays up when the next word follows with no gap
   task automatic send_access(input logic [47:0] addr, output int n);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_access_address <= addr;
      do @(posedge clock); while (!req_ready);
      n = predict_access(addr);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (prefetch_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write, only while idle
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         mhp_pkg::REG_BLOCK_SIZE_LOG2: shadow_cfg.block_size_log2 = value[3:0];
         mhp_pkg::REG_ISSUE_DEGREE:    shadow_cfg.issue_degree = value[2:0];
         mhp_pkg::REG_CANDIDATE_LIMIT: shadow_cfg.candidate_limit = value[2:0];
         mhp_pkg::REG_CONF_THRESHOLD:  shadow_cfg.confidence_threshold = value;
         mhp_pkg::REG_CONF_CEILING:    shadow_cfg.confidence_ceiling = value;
         mhp_pkg::REG_CONF_START:      shadow_cfg.confidence_start = value;
         default: ;
      endcase
   endtask

   // result side: random stalls, compare each prefetch word
   initial begin : rsp_side
      int stall;
      prefetch_word_type exp_w;
      @(negedge reset);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 14);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (prefetch_q.size() == 0) begin
            flag($sformatf("unexpected word addr=%h last=%b",
                           rsp_prefetch_address, rsp_last_of_run));
         end else begin
            exp_w = prefetch_q.pop_front();
            if (rsp_prefetch_address !== exp_w.addr || rsp_last_of_run !== exp_w.last)
               flag($sformatf("word exp addr=%h last=%b got addr=%h last=%b",
                              exp_w.addr, exp_w.last, rsp_prefetch_address,
                              rsp_last_of_run));
         end
      end
   end

   initial begin : stimulus
      row_type rows [$];
      logic [7:0] plan [PHASES][6];
      logic [47:0] pool [6];
      logic [47:0] addr, prev_addr, mask;
      int n, pos, plen, got, r;

      shadow_cfg = '{block_size_log2: 4'd6, issue_degree: 3'd2, candidate_limit: 3'd4,
                     confidence_threshold: 8'd1, confidence_ceiling: 8'd3,
                     confidence_start: 8'd1};
      last_block = '0;
      foreach (hist[i]) hist[i] = '0;
      foreach (valid_row[i]) valid_row[i] = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed table; want_n < 0 leaves the count to the shadow
      rows = '{
         '{0, 3'd0, 48'h0, 0},                 // block zero right after reset: dropped
         '{0, 3'd0, 48'h3f, 0},                // still block zero
         '{0, 3'd0, 48'h40, -1},
         '{0, 3'd0, 48'hffff_ffff_ffff, -1},
         '{0, 3'd0, 48'hffff_ffff_ffc0, 0},    // same block again
         '{0, 3'd0, 48'h1000, -1},
         '{0, 3'd0, 48'h2000, -1},
         '{0, 3'd0, 48'h1000, -1},
         '{0, 3'd0, 48'h2000, -1},
         '{0, 3'd0, 48'h1000, -1},
         '{1, mhp_pkg::REG_ISSUE_DEGREE, 48'd7, 0},    // degree above four
         '{1, mhp_pkg::REG_CANDIDATE_LIMIT, 48'd7, 0}, // limit above capacity
         '{1, mhp_pkg::REG_BLOCK_SIZE_LOG2, 48'd15, 0}, // widest mask
         '{0, 3'd0, 48'h2000, -1},
         '{0, 3'd0, 48'h1000, 0},              // same 32K block
         '{0, 3'd0, 48'h8000_0000, -1},
         '{1, mhp_pkg::REG_CANDIDATE_LIMIT, 48'd0, 0}, // replace only
         '{1, mhp_pkg::REG_CONF_THRESHOLD, 48'd0, 0},
         '{1, mhp_pkg::REG_CONF_CEILING, 48'd0, 0},
         '{1, mhp_pkg::REG_CONF_START, 48'd255, 0},
         '{0, 3'd0, 48'h0, -1},
         '{0, 3'd0, 48'h8000_0000, -1},
         '{1, mhp_pkg::REG_ISSUE_DEGREE, 48'd0, 0},
         '{0, 3'd0, 48'h0, 0},                 // degree zero: no words
         '{0, 3'd0, 48'h8000_0000, 0}
      };
      foreach (rows[i]) begin
         if (rows[i].is_csr) begin
            drain();
            write_reg(rows[i].idx, rows[i].value[7:0]);
         end else begin
            send_access(rows[i].value, n);
            if (rows[i].want_n >= 0 && (n < 0 ? 0 : n) != rows[i].want_n)
               flag($sformatf("row %0d: %0d words, table says %0d", i, n,
                              rows[i].want_n));
         end
      end

      // random phases: block_size, degree, limit, threshold, ceiling, start
      plan = '{
         '{8'd6, 8'd2, 8'd4, 8'd1, 8'd3, 8'd1},
         '{8'd2, 8'd4, 8'd4, 8'd0, 8'd255, 8'd255},
         '{8'd12, 8'd7, 8'd1, 8'd255, 8'd255, 8'd255},
         '{8'd15, 8'd3, 8'd0, 8'd1, 8'd2, 8'd0},
         '{8'd6, 8'd4, 8'd7, 8'd2, 8'd5, 8'd1},
         '{8'd4, 8'd1, 8'd2, 8'd0, 8'd0, 8'd0},
         '{8'd3, 8'd4, 8'd3, 8'd1, 8'd255, 8'd1},
         '{8'd8, 8'd2, 8'd4, 8'd3, 8'd3, 8'd2}
      };
      prev_addr = '0;
      for (int p = 0; p < PHASES; p++) begin
         drain();
         quiet = (p % 3 == 2);
         write_reg(mhp_pkg::REG_BLOCK_SIZE_LOG2, plan[p][0]);
         write_reg(mhp_pkg::REG_ISSUE_DEGREE, plan[p][1]);
         write_reg(mhp_pkg::REG_CANDIDATE_LIMIT, plan[p][2]);
         write_reg(mhp_pkg::REG_CONF_THRESHOLD, plan[p][3]);
         write_reg(mhp_pkg::REG_CONF_CEILING, plan[p][4]);
         write_reg(mhp_pkg::REG_CONF_START, plan[p][5]);
         mask = (48'd1 << shadow_cfg.block_size_log2) - 48'd1;
         foreach (pool[i]) pool[i] = 48'({$urandom, $urandom});
         plen = $urandom_range(2, 6);
         pos = 0;
         got = 0;
         while (got < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               // repeating block pattern with random offset
               addr = (pool[pos % plen] & ~mask) | (48'({$urandom, $urandom}) & mask);
               pos++;
            end else if (r < 85) begin
               addr = prev_addr ^ (48'({$urandom, $urandom}) & mask);
            end else begin
               addr = 48'({$urandom, $urandom});
            end
            prev_addr = addr;
            send_access(addr, n);
            if (n >= 0)
               got++;
         end
      end

      req_valid <= 1'b0;
      while (prefetch_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
